@@ hdl/modexp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types for the modular exponentiation block.
// No dependencies.
package modexp_pkg;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_BIT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } seq_state_t;

    // Status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

@@ hdl/modexp_mulmod.sv @@
`timescale 1ns / 1ps
// Bit-serial interleaved modular multiplier: (a * b) mod m, one bit of b per cycle.
// Depends on modexp_pkg.
module modexp_mulmod import modexp_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic [WIDTH-1:0] modulus,
    output logic [WIDTH-1:0] result,
    output mm_status_t       status
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   dbl_sum, add_sum;
    logic [WIDTH-1:0] dbl_red, add_red, addend;

    // acc = 2*acc mod m, then + (bit ? a : 0) mod m; both terms below m
    always_comb begin
        dbl_sum = {1'b0, acc_reg} + {1'b0, acc_reg};
        dbl_red = (dbl_sum >= {1'b0, modulus}) ? WIDTH'(dbl_sum - {1'b0, modulus})
                                               : dbl_sum[WIDTH-1:0];
        addend  = b_reg[WIDTH-1] ? a_reg : '0;
        add_sum = {1'b0, dbl_red} + {1'b0, addend};
        add_red = (add_sum >= {1'b0, modulus}) ? WIDTH'(add_sum - {1'b0, modulus})
                                               : add_sum[WIDTH-1:0];
    end

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            acc_next = add_red;
            b_next   = {b_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            cnt_next  = CW'(WIDTH - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign result      = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ hdl/modular_exponentiation_top.sv @@
`timescale 1ns / 1ps
// Modular exponentiation, right-to-left square-and-multiply, one shared
// bit-serial modular multiplier, each product ending with its done pulse.
// Sequence: a reduction of the base, then per bit up to the top set one a decision
// step, a square and, for a set bit, a multiply.
// Requests: one at a time, the next taken the cycle after the result loads;
// a result not yet taken holds the load back.
// Reset: synchronous, active low; modulus returns to 1, no result pending.
module modular_exponentiation_top import modexp_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration: modulus
    input  logic             cfg_we,
    input  logic [WIDTH-1:0] cfg_wdata,
    // request channel
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [WIDTH-1:0] s_base_value,
    input  logic [WIDTH-1:0] s_exponent,
    // result channel
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_power_result
);

    seq_state_t       state_reg, state_next;
    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] base_reg, base_next;   // running base, squared each bit
    logic [WIDTH-1:0] exp_reg, exp_next;     // exponent, shifted right each bit
    logic [WIDTH-1:0] r_reg, r_next;         // running result
    logic [WIDTH-1:0] out_reg, out_next;     // output holding register
    logic             m_valid_reg, m_valid_next;

    // multiplier interface
    logic             mm_start;
    logic [WIDTH-1:0] mm_a, mm_b, mm_result;
    mm_status_t       mm_status;

    logic [WIDTH-1:0] one_mod;   // 1 mod m: 0 when the modulus is one
    logic             load_out;

    assign one_mod = (modulus_reg == WIDTH'(1)) ? '0 : WIDTH'(1);

    modexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (modulus_reg),
        .result  (mm_result),
        .status  (mm_status)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        r_next     = r_reg;
        mm_start   = 1'b0;
        mm_a       = base_reg;
        mm_b       = base_reg;
        load_out   = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    exp_next = s_exponent;
                    if (modulus_reg == '0) begin
                        // no reduction defined: result is zero
                        r_next     = '0;
                        state_next = ST_DONE;
                    end else begin
                        // base mod m as (1 mod m) * base
                        mm_start   = 1'b1;
                        mm_a       = one_mod;
                        mm_b       = s_base_value;
                        state_next = ST_RED;
                    end
                end
            end
            ST_RED: begin
                if (mm_status.done) begin
                    base_next  = mm_result;
                    r_next     = one_mod;
                    state_next = ST_BIT;
                end
            end
            ST_BIT: begin
                // remaining bits all clear: result is final
                if (exp_reg == '0) begin
                    state_next = ST_DONE;
                end else if (exp_reg[0]) begin
                    mm_start   = 1'b1;
                    mm_a       = r_reg;
                    mm_b       = base_reg;
                    state_next = ST_MUL;
                end else begin
                    mm_start   = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_MUL: begin
                if (mm_status.done) begin
                    r_next     = mm_result;
                    mm_start   = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                if (mm_status.done) begin
                    base_next  = mm_result;
                    exp_next   = {1'b0, exp_reg[WIDTH-1:1]};
                    state_next = ST_BIT;
                end
            end
            ST_DONE: begin
                // wait for the output register to be free
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: holds the result until taken
    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load_out) begin
            out_next     = r_reg;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        r_reg    <= r_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            modulus_reg <= WIDTH'(1);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                modulus_reg <= cfg_wdata;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_power_result = out_reg;

endmodule
